// ----- hdl/rcq_pkg.sv -----
// Shared types and constants of the retransmit command queue.
// No dependencies; every other file of the block imports it.
package rcq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TICK_LIMIT  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ERROR_LIMIT = 4'd1;

    localparam logic [3:0] TICK_LIMIT_RESET  = 4'd3;
    localparam logic [4:0] ERROR_LIMIT_RESET = 5'd5;

    // command codes
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    // error event codes
    localparam logic [1:0] EVT_NONE    = 2'd0;
    localparam logic [1:0] EVT_RAISED  = 2'd1;
    localparam logic [1:0] EVT_CLEARED = 2'd2;

    localparam logic [7:0] NOQUEUE_CODE = 8'h0a;
    localparam logic [7:0] ACK_MASK     = 8'h0f;
    localparam logic [4:0] RESEND_MAX   = 5'd31;

    typedef struct packed {
        logic [7:0]  ftype;
        logic [7:0]  fcode;
        logic [31:0] farg;
    } frame_t;

    typedef struct packed {
        logic shift;   // take the neighbour's entry (head removed)
        logic load;    // take the incoming request
    } cell_ctl_t;

endpackage

// ----- hdl/rcq_cell.sv -----
// One entry of the shifting frame queue.
// Depends on rcq_pkg for frame_t and cell_ctl_t.
module rcq_cell (
    input  logic               clk,
    input  rcq_pkg::cell_ctl_t ctl,
    input  rcq_pkg::frame_t    load_frame,
    input  rcq_pkg::frame_t    shift_frame,
    output rcq_pkg::frame_t    frame
);
    import rcq_pkg::*;

    frame_t frame_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            frame_reg <= load_frame;
        end
        else if (ctl.shift)
        begin
            frame_reg <= shift_frame;
        end
    end

    assign frame = frame_reg;

endmodule

// ----- hdl/retransmit_command_queue.sv -----
// Retransmit command queue: top level, control counters and the cell row.
// Depends on rcq_pkg and rcq_cell.
//
// Stop-and-wait retransmit queue for commands to a microcontroller. Each input
// transaction (send request, acknowledgement or timer tick) yields exactly one
// output transaction, registered, in the cycle after acceptance. A new input
// transaction is taken every cycle unless the output register holds a result
// that is stalled, so the block sustains one transaction per cycle; the figure
// is set by the single output register. Pending frames sit in a row of DEPTH
// cells with the head always in cell 0: an acknowledgement that matches the
// head shifts every cell one place towards the head, a queued request loads
// the cell just past the last filled one. Only filled cells are ever read, so
// the row needs no reset. The configuration port is always ready; write the
// limits only while no transaction is in flight.
module retransmit_command_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rcq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rcq_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      cmd,
    input  logic [7:0]                      frame_type,
    input  logic [7:0]                      frame_code,
    input  logic [31:0]                     frame_arg,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            send_valid,
    output logic [7:0]                      send_type,
    output logic [7:0]                      send_code,
    output logic [31:0]                     send_arg,
    output logic [1:0]                      error_event,
    output logic                            overflow,
    output logic [4:0]                      pending_count
);
    import rcq_pkg::*;

    // configuration
    logic [3:0] tick_limit_reg;
    logic [4:0] error_limit_reg;

    // control state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       wait_reg, wait_next;
    logic [4:0]       resend_reg, resend_next;
    logic             err_reg, err_next;

    // output register
    logic        out_valid_reg;
    logic        send_valid_reg, send_valid_next;
    frame_t      send_frame_reg, send_frame_next;
    logic [1:0]  event_reg, event_next;
    logic        overflow_reg, overflow_next;
    logic [4:0]  pending_reg;

    logic        accept;
    frame_t      req;
    frame_t      cells [DEPTH];
    cell_ctl_t   ctl   [DEPTH];
    logic        do_shift;
    logic        do_load;
    logic [4:0]  wait_inc;
    logic [4:0]  resend_inc;

    assign cfg_ready = 1'b1;
    // a new transaction may enter when the output register is free or draining
    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;

    assign req.ftype = frame_type;
    assign req.fcode = frame_code;
    assign req.farg  = frame_arg;

    assign wait_inc = {1'b0, wait_reg} + 5'd1;

    always_comb
    begin
        count_next      = count_reg;
        wait_next       = wait_reg;
        resend_next     = resend_reg;
        err_next        = err_reg;
        send_valid_next = 1'b0;
        send_frame_next = '0;
        event_next      = EVT_NONE;
        overflow_next   = 1'b0;
        do_shift        = 1'b0;
        do_load         = 1'b0;
        resend_inc      = resend_reg;

        case (cmd)
            CMD_SEND:
            begin
                if (count_reg == '0)
                begin
                    send_valid_next = 1'b1;
                    send_frame_next = req;
                end
                if (frame_code != NOQUEUE_CODE)
                begin
                    if (count_reg >= CNT_W'(DEPTH))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        do_load    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            CMD_ACK:
            begin
                // head code is compared in full against the masked ack code
                if (count_reg != '0 && (frame_code & ACK_MASK) == cells[0].fcode)
                begin
                    do_shift    = 1'b1;
                    count_next  = count_reg - CNT_W'(1);
                    wait_next   = '0;
                    resend_next = '0;
                    if (count_reg > CNT_W'(1))
                    begin
                        send_valid_next = 1'b1;
                        send_frame_next = cells[1];
                    end
                end
            end
            CMD_TICK:
            begin
                if (count_reg != '0)
                begin
                    if (wait_inc > {1'b0, tick_limit_reg})
                    begin
                        wait_next       = '0;
                        send_valid_next = 1'b1;
                        send_frame_next = cells[0];
                        if (resend_reg < RESEND_MAX)
                        begin
                            resend_inc = resend_reg + 5'd1;
                        end
                        resend_next = resend_inc;
                        if (resend_inc > error_limit_reg)
                        begin
                            err_next   = 1'b1;
                            event_next = EVT_RAISED;
                        end
                    end
                    else
                    begin
                        wait_next = wait_inc[3:0];
                    end
                end
                else
                begin
                    wait_next   = '0;
                    resend_next = '0;
                    if (err_reg)
                    begin
                        err_next   = 1'b0;
                        event_next = EVT_CLEARED;
                    end
                end
            end
            default:
            begin
                // unused command: only the count is reported
            end
        endcase
    end

    // cell row: cell 0 is the head, cell i shifts in from cell i+1
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        frame_t shift_in;

        if (i == DEPTH - 1)
        begin : g_last
            assign shift_in = '0;
        end
        else
        begin : g_mid
            assign shift_in = cells[i+1];
        end

        assign ctl[i].shift = accept & do_shift;
        assign ctl[i].load  = accept & do_load & (count_reg[IDX_W-1:0] == IDX_W'(i));

        rcq_cell u_cell (
            .clk         (clk),
            .ctl         (ctl[i]),
            .load_frame  (req),
            .shift_frame (shift_in),
            .frame       (cells[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_limit_reg  <= TICK_LIMIT_RESET;
            error_limit_reg <= ERROR_LIMIT_RESET;
            count_reg       <= '0;
            wait_reg        <= '0;
            resend_reg      <= '0;
            err_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_TICK_LIMIT:  tick_limit_reg  <= cfg_data[3:0];
                    REG_ERROR_LIMIT: error_limit_reg <= cfg_data[4:0];
                    default:         ;
                endcase
            end
            if (accept)
            begin
                count_reg     <= count_next;
                wait_reg      <= wait_next;
                resend_reg    <= resend_next;
                err_reg       <= err_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, held while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_valid_reg <= send_valid_next;
            send_frame_reg <= send_frame_next;
            event_reg      <= event_next;
            overflow_reg   <= overflow_next;
            pending_reg    <= 5'(count_next);
        end
    end

    assign out_valid     = out_valid_reg;
    assign send_valid    = send_valid_reg;
    assign send_type     = send_frame_reg.ftype;
    assign send_code     = send_frame_reg.fcode;
    assign send_arg      = send_frame_reg.farg;
    assign error_event   = event_reg;
    assign overflow      = overflow_reg;
    assign pending_count = pending_reg;

endmodule

// ----- hdl/rcq_checker.sv -----
// Port-level checks of the retransmit command queue, bound to the top level.
// Depends on rcq_pkg and retransmit_command_queue.
module rcq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        send_valid,
    input logic [7:0]  send_type,
    input logic [7:0]  send_code,
    input logic [31:0] send_arg,
    input logic [1:0]  error_event,
    input logic        overflow,
    input logic [4:0]  pending_count
);
    import rcq_pkg::*;

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(send_valid) && $stable(send_arg)
            && $stable(error_event) && $stable(pending_count))
        else $error("stalled output transaction changed");

    // no frame sent means an all-zero frame
    a_idle_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !send_valid |-> send_type == 8'd0 && send_code == 8'd0 && send_arg == 32'd0)
        else $error("frame fields set without a transmission");

    // a dropped request leaves a full queue and sends nothing
    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> pending_count == 5'(DEPTH) && !send_valid)
        else $error("overflow with queue not full");

    // error is cleared only on an idle tick
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_event == EVT_CLEARED |-> pending_count == 5'd0 && !send_valid)
        else $error("error cleared with work pending");

    // a raised error always comes with a resend
    a_raise: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_event == EVT_RAISED |-> send_valid && pending_count != 5'd0)
        else $error("error raised without a resend");

endmodule

bind retransmit_command_queue rcq_checker u_rcq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .send_valid    (send_valid),
    .send_type     (send_type),
    .send_code     (send_code),
    .send_arg      (send_arg),
    .error_event   (error_event),
    .overflow      (overflow),
    .pending_count (pending_count)
);
